// ===== hw/rtl/sprite_batch_coalescer_top_macros.svh =====
// Assertion macros shared by the sprite batch coalescer RTL.
`ifndef SPRITE_BATCH_COALESCER_TOP_MACROS_SVH
`define SPRITE_BATCH_COALESCER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sbc_pkg.sv =====
// Types and codes shared by the sprite batch coalescer.
package sbc_pkg;

   // Result kinds
   localparam logic [1:0] KIND_DIAG   = 2'd0;
   localparam logic [1:0] KIND_BATCH  = 2'd1;
   localparam logic [1:0] KIND_TOTALS = 2'd2;

   // Diagnostic codes
   localparam logic [1:0] DIAG_UNTEXTURED = 2'd0;
   localparam logic [1:0] DIAG_NO_ATLAS   = 2'd1;
   localparam logic [1:0] DIAG_BAD_UV     = 2'd2;
   localparam logic [1:0] DIAG_REORDER    = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQUIRE_ATLAS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REORDER       = 1'd1;

   // Result slots, in the order they leave the block
   localparam int unsigned SLOT_COUNT = 4;
   localparam logic [1:0] SLOT_DIAG   = 2'd0;
   localparam logic [1:0] SLOT_CLOSED = 2'd1;
   localparam logic [1:0] SLOT_FINAL  = 2'd2;
   localparam logic [1:0] SLOT_TOTALS = 2'd3;

   // One result as it appears on the response port
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  diag_code;
      logic [15:0] position;
      logic [16:0] item_count;
      logic        textured;
      logic [31:0] page;
      logic [16:0] draw_total;
      logic [16:0] textured_total;
      logic [16:0] bind_total;
      logic [16:0] repeated_batch_total;
      logic [16:0] repeated_sprite_total;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/sprite_batch_coalescer_top.sv =====
// Sprite batch coalescer: classifies sprites and merges runs into batch ranges (reorder off).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  req_    | in        | req_valid / req_stall | one sprite command
//  rsp_    | out       | rsp_valid / rsp_stall | diagnostic, batch range or totals
//  csr_    | in        | csr_write_enable      | csr_index, csr_write_data
//
// A request is classified and the frame state updated in the cycle it is accepted; its
// results (0 to 4) sit in a four-slot result register and leave one per cycle unless
// the result side stalls. A request with at most one result is followed by the next in
// the next cycle, stalls aside; one with more holds the input until one result is left.
// Reset (synchronous, active high) clears the configuration, the pending flags and
// the frame state.
// A stall on the result side holds the result register and, while any result is
// pending, the input side too.
module sprite_batch_coalescer_top
   import sbc_pkg::*;
#(
   parameter int unsigned INDEX_BITS = 16,
   parameter int unsigned PAGE_BITS  = 32,
   parameter int unsigned UV_ONE     = 16384
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic                    csr_write_data,
   // sprite requests
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_texture_enabled,
   input  logic [31:0]             req_atlas_page,
   input  logic signed [15:0]      req_uv_u0,
   input  logic signed [15:0]      req_uv_v0,
   input  logic signed [15:0]      req_uv_u1,
   input  logic signed [15:0]      req_uv_v1,
   input  logic                    req_frame_end,
   // results
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_result_kind,
   output logic [1:0]              rsp_diag_code,
   output logic [15:0]             rsp_sprite_position,
   output logic [16:0]             rsp_item_count,
   output logic                    rsp_batch_textured,
   output logic [31:0]             rsp_batch_page,
   output logic [16:0]             rsp_draw_total,
   output logic [16:0]             rsp_textured_total,
   output logic [16:0]             rsp_bind_total,
   output logic [16:0]             rsp_repeated_batch_total,
   output logic [16:0]             rsp_repeated_sprite_total,
   output logic                    rsp_last_of_run
);

   `include "sprite_batch_coalescer_top_macros.svh"

   localparam int unsigned CW = INDEX_BITS + 1;
   localparam int unsigned PW = (PAGE_BITS < 32) ? PAGE_BITS : 32;
   localparam logic [CW-1:0] Cap   = {1'b1, {INDEX_BITS{1'b0}}};
   localparam logic [CW-1:0] CapM1 = {1'b0, {INDEX_BITS{1'b1}}};
   localparam logic [CW-1:0] One   = {{INDEX_BITS{1'b0}}, 1'b1};
   localparam logic signed [15:0] UvOne = 16'(UV_ONE);

   // Add two counts, clamping at the cap
   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = (s >= {1'b0, Cap}) ? Cap : s[CW-1:0];
   endfunction

   // Configuration registers
   logic require_atlas_ff, reorder_ff;

   // Frame state
   logic                  batch_open_ff, batch_open_in;
   logic                  open_tex_ff, open_tex_in;
   logic [PW-1:0]         open_page_ff, open_page_in;
   logic [INDEX_BITS-1:0] open_first_ff, open_first_in;
   logic [CW-1:0]         open_count_ff, open_count_in;
   logic [CW-1:0]         next_index_ff, next_index_in;
   logic [CW-1:0]         batches_ff, batches_in;
   logic [CW-1:0]         textured_ff, textured_in;
   logic [CW-1:0]         binds_ff, binds_in;
   logic [CW-1:0]         rep_batches_ff, rep_batches_in;
   logic [CW-1:0]         rep_sprites_ff, rep_sprites_in;

   // Result register
   logic [SLOT_COUNT-1:0] pend_ff, pend_in;
   rsp_type               slot_ff [SLOT_COUNT];
   rsp_type               slot_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] new_pend;

   // Working values
   logic                  accept, pop;
   logic [1:0]            sel;
   rsp_type               rsp_cur;
   logic [INDEX_BITS-1:0] pos;
   logic [CW-1:0]         idx_inc;
   logic [PW-1:0]         in_page;
   logic                  uv_ok;
   logic                  diag_en;
   logic [1:0]            diag_code;
   logic                  tex;
   logic [PW-1:0]         page;
   logic [CW-1:0]         tex_cnt;
   logic                  match, close1;
   logic [CW-1:0]         b1, bind1, rb1, rs1;
   logic                  tex2;
   logic [PW-1:0]         page2;
   logic [INDEX_BITS-1:0] first2;
   logic [CW-1:0]         cnt2;
   logic [CW-1:0]         b2, bind2, rb2, rs2;

   // Handshakes: take a request when the result register is empty or empties this cycle
   assign pop       = rsp_valid & ~rsp_stall;
   assign req_stall = ((pend_ff & (pend_ff - 4'd1)) != 4'd0) || ((pend_ff != 4'd0) && rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Classify the sprite and work out its batch effect
   always_comb begin
      pos     = (next_index_ff > CapM1) ? CapM1[INDEX_BITS-1:0] : next_index_ff[INDEX_BITS-1:0];
      idx_inc = sat_add(next_index_ff, One);
      in_page = req_atlas_page[PW-1:0];
      uv_ok   = (req_uv_u0 >= 16'sd0) && (req_uv_v0 >= 16'sd0) &&
                (req_uv_u1 <= UvOne) && (req_uv_v1 <= UvOne) &&
                (req_uv_u0 < req_uv_u1) && (req_uv_v0 < req_uv_v1);

      diag_en   = 1'b0;
      diag_code = DIAG_UNTEXTURED;
      tex       = 1'b0;
      page      = '0;
      if (!req_texture_enabled) begin
         diag_en = require_atlas_ff;
      end else if (in_page == '0) begin
         diag_en   = 1'b1;
         diag_code = DIAG_NO_ATLAS;
      end else if (!uv_ok) begin
         diag_en   = 1'b1;
         diag_code = DIAG_BAD_UV;
      end else begin
         tex  = 1'b1;
         page = in_page;
      end
      tex_cnt = tex ? sat_add(textured_ff, One) : textured_ff;

      // Extend the open batch or close it
      match  = batch_open_ff && (open_tex_ff == tex) && (open_page_ff == page);
      close1 = batch_open_ff & ~match;
      b1     = close1 ? sat_add(batches_ff, One) : batches_ff;
      bind1  = (close1 && open_tex_ff) ? sat_add(binds_ff, One) : binds_ff;
      if (close1 && open_tex_ff && (open_count_ff > One)) begin
         rb1 = sat_add(rep_batches_ff, One);
         rs1 = sat_add(rep_sprites_ff, open_count_ff);
      end else begin
         rb1 = rep_batches_ff;
         rs1 = rep_sprites_ff;
      end

      if (match) begin
         tex2   = open_tex_ff;
         page2  = open_page_ff;
         first2 = open_first_ff;
         cnt2   = sat_add(open_count_ff, One);
      end else begin
         tex2   = tex;
         page2  = page;
         first2 = pos;
         cnt2   = One;
      end

      // Close the final batch of the frame
      b2    = sat_add(b1, One);
      bind2 = tex2 ? sat_add(bind1, One) : bind1;
      if (tex2 && (cnt2 > One)) begin
         rb2 = sat_add(rb1, One);
         rs2 = sat_add(rs1, cnt2);
      end else begin
         rb2 = rb1;
         rs2 = rs1;
      end
   end

   // Build the results of this request
   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         slot_in[k] = '0;
      end
      new_pend = '0;

      if (reorder_ff) begin
         new_pend[SLOT_DIAG]   = req_frame_end;
         new_pend[SLOT_TOTALS] = req_frame_end;
         slot_in[SLOT_DIAG].kind        = KIND_DIAG;
         slot_in[SLOT_DIAG].diag_code   = DIAG_REORDER;
         slot_in[SLOT_TOTALS].kind       = KIND_TOTALS;
         slot_in[SLOT_TOTALS].item_count = 17'(idx_inc);
      end else begin
         new_pend[SLOT_DIAG]   = diag_en;
         new_pend[SLOT_CLOSED] = close1;
         new_pend[SLOT_FINAL]  = req_frame_end;
         new_pend[SLOT_TOTALS] = req_frame_end;

         slot_in[SLOT_DIAG].kind      = KIND_DIAG;
         slot_in[SLOT_DIAG].diag_code = diag_code;
         slot_in[SLOT_DIAG].position  = 16'(pos);

         slot_in[SLOT_CLOSED].kind       = KIND_BATCH;
         slot_in[SLOT_CLOSED].position   = 16'(open_first_ff);
         slot_in[SLOT_CLOSED].item_count = 17'(open_count_ff);
         slot_in[SLOT_CLOSED].textured   = open_tex_ff;
         slot_in[SLOT_CLOSED].page       = 32'(open_page_ff);

         slot_in[SLOT_FINAL].kind       = KIND_BATCH;
         slot_in[SLOT_FINAL].position   = 16'(first2);
         slot_in[SLOT_FINAL].item_count = 17'(cnt2);
         slot_in[SLOT_FINAL].textured   = tex2;
         slot_in[SLOT_FINAL].page       = 32'(page2);

         slot_in[SLOT_TOTALS].kind                  = KIND_TOTALS;
         slot_in[SLOT_TOTALS].item_count            = 17'(idx_inc);
         slot_in[SLOT_TOTALS].draw_total            = 17'(b2);
         slot_in[SLOT_TOTALS].textured_total        = 17'(tex_cnt);
         slot_in[SLOT_TOTALS].bind_total            = 17'(bind2);
         slot_in[SLOT_TOTALS].repeated_batch_total  = 17'(rb2);
         slot_in[SLOT_TOTALS].repeated_sprite_total = 17'(rs2);
      end

      // Mark the highest pending slot as the last of the run
      slot_in[SLOT_TOTALS].last = new_pend[SLOT_TOTALS];
      slot_in[SLOT_FINAL].last  = new_pend[SLOT_FINAL] & ~new_pend[SLOT_TOTALS];
      slot_in[SLOT_CLOSED].last = new_pend[SLOT_CLOSED] & ~new_pend[SLOT_FINAL] &
                                  ~new_pend[SLOT_TOTALS];
      slot_in[SLOT_DIAG].last   = new_pend[SLOT_DIAG] & ~new_pend[SLOT_CLOSED] &
                                  ~new_pend[SLOT_FINAL] & ~new_pend[SLOT_TOTALS];
   end

   // Next frame state
   always_comb begin
      batch_open_in  = batch_open_ff;
      open_tex_in    = open_tex_ff;
      open_page_in   = open_page_ff;
      open_first_in  = open_first_ff;
      open_count_in  = open_count_ff;
      next_index_in  = next_index_ff;
      batches_in     = batches_ff;
      textured_in    = textured_ff;
      binds_in       = binds_ff;
      rep_batches_in = rep_batches_ff;
      rep_sprites_in = rep_sprites_ff;
      if (accept) begin
         if (req_frame_end) begin
            batch_open_in  = 1'b0;
            open_tex_in    = 1'b0;
            open_page_in   = '0;
            open_first_in  = '0;
            open_count_in  = '0;
            next_index_in  = '0;
            batches_in     = '0;
            textured_in    = '0;
            binds_in       = '0;
            rep_batches_in = '0;
            rep_sprites_in = '0;
         end else if (reorder_ff) begin
            next_index_in = idx_inc;
         end else begin
            batch_open_in  = 1'b1;
            open_tex_in    = tex2;
            open_page_in   = page2;
            open_first_in  = first2;
            open_count_in  = cnt2;
            next_index_in  = idx_inc;
            batches_in     = b1;
            textured_in    = tex_cnt;
            binds_in       = bind1;
            rep_batches_in = rb1;
            rep_sprites_in = rs1;
         end
      end
   end

   // Pick the oldest pending result
   always_comb begin
      sel = SLOT_TOTALS;
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            sel = 2'(k);
         end
      end
      rsp_cur = slot_ff[sel];
   end

   // Drop the delivered result, load a new run on accept
   always_comb begin
      pend_in = pend_ff;
      if (pop) begin
         pend_in = pend_ff & ~(4'd1 << sel);
      end
      if (accept) begin
         pend_in = new_pend;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         require_atlas_ff <= 1'b0;
         reorder_ff       <= 1'b0;
         pend_ff          <= '0;
         batch_open_ff    <= 1'b0;
         open_tex_ff      <= 1'b0;
         open_page_ff     <= '0;
         open_first_ff    <= '0;
         open_count_ff    <= '0;
         next_index_ff    <= '0;
         batches_ff       <= '0;
         textured_ff      <= '0;
         binds_ff         <= '0;
         rep_batches_ff   <= '0;
         rep_sprites_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REQUIRE_ATLAS: require_atlas_ff <= csr_write_data;
               CSR_REORDER:       reorder_ff       <= csr_write_data;
               default:           ;
            endcase
         end
         pend_ff        <= pend_in;
         batch_open_ff  <= batch_open_in;
         open_tex_ff    <= open_tex_in;
         open_page_ff   <= open_page_in;
         open_first_ff  <= open_first_in;
         open_count_ff  <= open_count_in;
         next_index_ff  <= next_index_in;
         batches_ff     <= batches_in;
         textured_ff    <= textured_in;
         binds_ff       <= binds_in;
         rep_batches_ff <= rep_batches_in;
         rep_sprites_ff <= rep_sprites_in;
      end
   end

   // Result payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_ff[k] <= slot_in[k];
         end
      end
   end

   // Response port
   assign rsp_valid                 = pend_ff != 4'd0;
   assign rsp_result_kind           = rsp_cur.kind;
   assign rsp_diag_code             = rsp_cur.diag_code;
   assign rsp_sprite_position       = rsp_cur.position;
   assign rsp_item_count            = rsp_cur.item_count;
   assign rsp_batch_textured        = rsp_cur.textured;
   assign rsp_batch_page            = rsp_cur.page;
   assign rsp_draw_total            = rsp_cur.draw_total;
   assign rsp_textured_total        = rsp_cur.textured_total;
   assign rsp_bind_total            = rsp_cur.bind_total;
   assign rsp_repeated_batch_total  = rsp_cur.repeated_batch_total;
   assign rsp_repeated_sprite_total = rsp_cur.repeated_sprite_total;
   assign rsp_last_of_run           = rsp_cur.last;

   // Checks
   `SBC_ASSERT_NEXT(a_frame_end_totals, clock, reset, accept && req_frame_end,
                    pend_ff[SLOT_TOTALS], "frame end without totals pending")
   `SBC_ASSERT_NEXT(a_frame_end_clears, clock, reset, accept && req_frame_end,
                    next_index_ff == '0 && !batch_open_ff,
                    "frame state not cleared at frame end")
   `SBC_ASSERT_NOW(a_last_marks_end, clock, reset, rsp_valid,
                   rsp_last_of_run == $onehot(pend_ff),
                   "last_of_run disagrees with pending results")

endmodule
